FILE: hdl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and codes for the slice layer word parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

    localparam int WORD_W = 16;

    // Command words
    localparam logic [WORD_W-1:0] CMD_LAYER    = 16'd128;
    localparam logic [WORD_W-1:0] CMD_POLYLINE = 16'd129;

    // Parser phase codes
    localparam logic [2:0] PH_CMD  = 3'd0;
    localparam logic [2:0] PH_Z    = 3'd1;
    localparam logic [2:0] PH_ID   = 3'd2;
    localparam logic [2:0] PH_DIR  = 3'd3;
    localparam logic [2:0] PH_CNT  = 3'd4;
    localparam logic [2:0] PH_X    = 3'd5;
    localparam logic [2:0] PH_Y    = 3'd6;
    localparam logic [2:0] PH_STOP = 3'd7;

    // Event codes
    localparam logic [2:0] EV_CONSUMED = 3'd0;
    localparam logic [2:0] EV_LAYER    = 3'd1;
    localparam logic [2:0] EV_HEADER   = 3'd2;
    localparam logic [2:0] EV_POINT    = 3'd3;
    localparam logic [2:0] EV_STOPPED  = 3'd4;
    localparam logic [2:0] EV_IGNORED  = 3'd5;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [2:0] event_res;
        word_t      layer_height;
        word_t      line_id;
        word_t      line_dir;
        word_t      point_count;
        word_t      point_x;
        word_t      point_y;
        logic       last_point;
        word_t      stop_word;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/slp_core.sv
// ----------------------------------------------------------------------------
// slp_core
// Parser state and per-beat decode of one stream word into one result.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire slp_pkg::word_t  word,
    output slp_pkg::result_t     result
);
    import slp_pkg::*;

    logic [2:0] phase_reg, phase_next;
    word_t      points_left_reg, points_left_next;
    word_t      held_x_reg, held_x_next;
    word_t      held_id_reg, held_id_next;
    word_t      held_dir_reg, held_dir_next;
    word_t      points_dec;

    assign points_dec = points_left_reg - word_t'(1);

    always_comb begin
        result           = '0;
        result.event_res = EV_CONSUMED;
        phase_next       = phase_reg;
        points_left_next = points_left_reg;
        held_x_next      = held_x_reg;
        held_id_next     = held_id_reg;
        held_dir_next    = held_dir_reg;
        unique case (phase_reg)
            PH_CMD: begin
                if (word == CMD_LAYER) begin
                    phase_next = PH_Z;
                end else if (word == CMD_POLYLINE) begin
                    phase_next = PH_ID;
                end else begin
                    result.event_res = EV_STOPPED;
                    result.stop_word = word;
                    phase_next       = PH_STOP;
                end
            end
            PH_Z: begin
                result.event_res    = EV_LAYER;
                result.layer_height = word;
                phase_next          = PH_CMD;
            end
            PH_ID: begin
                held_id_next = word;
                phase_next   = PH_DIR;
            end
            PH_DIR: begin
                held_dir_next = word;
                phase_next    = PH_CNT;
            end
            PH_CNT: begin
                result.event_res   = EV_HEADER;
                result.line_id     = held_id_reg;
                result.line_dir    = held_dir_reg;
                result.point_count = word;
                points_left_next   = word;
                phase_next         = (word == '0) ? PH_CMD : PH_X;
            end
            PH_X: begin
                held_x_next = word;
                phase_next  = PH_Y;
            end
            PH_Y: begin
                result.event_res  = EV_POINT;
                result.point_x    = held_x_reg;
                result.point_y    = word;
                result.last_point = (points_left_reg == word_t'(1));
                points_left_next  = points_dec;
                phase_next        = (points_dec == '0) ? PH_CMD : PH_X;
            end
            default: begin
                result.event_res = EV_IGNORED;
                phase_next       = PH_STOP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_CMD;
            points_left_reg <= '0;
            held_x_reg      <= '0;
            held_id_reg     <= '0;
            held_dir_reg    <= '0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            points_left_reg <= points_left_next;
            held_x_reg      <= held_x_next;
            held_id_reg     <= held_id_next;
            held_dir_reg    <= held_dir_next;
        end
    end

    // Point phases always have a pair outstanding
    a_points_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_X || phase_reg == PH_Y) |-> (points_left_reg != '0))
        else $error("point phase with no points left");

    // Stop is sticky until reset
    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STOP) |=> (phase_reg == PH_STOP))
        else $error("parser left stopped phase");

    // Empty polyline returns straight to command phase
    a_empty_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_CNT && word == '0) |=> (phase_reg == PH_CMD))
        else $error("zero count did not return to command phase");

endmodule

`default_nettype wire

FILE: hdl/slp_out_stage.sv
// ----------------------------------------------------------------------------
// slp_out_stage
// Result register with a skid register behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire slp_pkg::result_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output slp_pkg::result_t       out_data
);
    import slp_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    in_fire;
    logic    main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end else if (in_fire) begin
            skid_reg <= in_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a beat while result register is empty");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid beat not moved forward");

    // A stalled result beat stays put until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result beat changed while stalled");

endmodule

`default_nettype wire

FILE: hdl/slice_layer_word_parser.sv
// ----------------------------------------------------------------------------
// slice_layer_word_parser
// Parses the binary body of a sliced layer file, one 16-bit word per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_word carry stream words. Every accepted word yields
//   exactly one result beat on m_valid/m_ready with the m_ fields.
//   Command 128 is followed by a height word (event 1 on the height word).
//   Command 129 is followed by id, direction and count words (event 2 on the
//   count word), then count x,y pairs (event 3 on each y word, last_point on
//   the final pair). Any other command gives event 4 and stops the parser;
//   every later word gives event 5 until reset. Fields not belonging to the
//   reported event read as zero.
// Timing:
//   Each accepted word's result is registered before it shows on m_valid.
//   One word per cycle sustained while m_ready is high: the parser decodes
//   each word combinationally and feeds the result register directly.
// Reset:
//   aresetn low (synchronous) returns the parser to the command phase and
//   empties the result and skid registers.
// Stalls:
//   While m_ready is low, one further word is still taken into the skid
//   register; after that s_ready drops until the receiver drains a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module slice_layer_word_parser (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // word stream
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [15:0]            s_word,
    // result stream
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [2:0]                  m_event_res,
    output logic [15:0]                 m_layer_height,
    output logic [15:0]                 m_line_id,
    output logic [15:0]                 m_line_dir,
    output logic [15:0]                 m_point_count,
    output logic [15:0]                 m_point_x,
    output logic [15:0]                 m_point_y,
    output logic                        m_last_point,
    output logic [15:0]                 m_stop_word
);
    import slp_pkg::*;

    logic    in_fire;
    result_t core_result;
    result_t out_result;

    // Advance the parser only on an accepted beat
    assign in_fire = s_valid && s_ready;

    slp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (in_fire),
        .word    (s_word),
        .result  (core_result)
    );

    // Hold results here so the parser can take one further beat under a stall
    slp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_event_res    = out_result.event_res;
    assign m_layer_height = out_result.layer_height;
    assign m_line_id      = out_result.line_id;
    assign m_line_dir     = out_result.line_dir;
    assign m_point_count  = out_result.point_count;
    assign m_point_x      = out_result.point_x;
    assign m_point_y      = out_result.point_y;
    assign m_last_point   = out_result.last_point;
    assign m_stop_word    = out_result.stop_word;

endmodule

`default_nettype wire
